### rtl/tvt_pkg.sv
// Package for the thermistor voltage to temperature converter.
// Field widths, the fixed (temperature, voltage) table, the operand bundle
// and the sequencer states. No dependencies.
package tvt_pkg;

	// Field and datapath widths
	localparam int VOLT_W  = 23;                // input voltage, uV
	localparam int OUT_W   = 19;                // output temperature, mC
	localparam int TEMP_W  = 20;                // table temperature, signed
	localparam int DT_W    = 18;                // temperature step between rows
	localparam int PROD_W  = DT_W + VOLT_W;     // step times voltage offset
	localparam int CNT_W   = $clog2(DT_W + 1);  // serial step counter

	// Table geometry
	localparam int ROM_ROWS          = 17;
	localparam int ROW_W             = $clog2(ROM_ROWS);
	localparam int TABLE_ENTRIES_DEF = 17;

	// Operands handed from the table search to the arithmetic
	typedef struct packed {
		logic                     clamp;  // t1 is the final answer
		logic signed [TEMP_W-1:0] t1;
		logic [DT_W-1:0]          dt;
		logic [VOLT_W-1:0]        dm;
		logic [VOLT_W-1:0]        dv;
	} lut_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIV
	} tvt_state_t;

	// Row temperature in mC
	function automatic logic signed [TEMP_W-1:0] rom_temp(input logic [ROW_W-1:0] idx);
		case (idx)
			0:       rom_temp = -20'sd30000;
			1:       rom_temp = 20'sd0;
			2:       rom_temp = 20'sd10000;
			3:       rom_temp = 20'sd20000;
			4:       rom_temp = 20'sd25000;
			5:       rom_temp = 20'sd30000;
			6:       rom_temp = 20'sd35000;
			7:       rom_temp = 20'sd40000;
			8:       rom_temp = 20'sd45000;
			9:       rom_temp = 20'sd50000;
			10:      rom_temp = 20'sd55000;
			11:      rom_temp = 20'sd60000;
			12:      rom_temp = 20'sd65000;
			13:      rom_temp = 20'sd80000;
			14:      rom_temp = 20'sd100000;
			15:      rom_temp = 20'sd150000;
			default: rom_temp = 20'sd200000;
		endcase
	endfunction

	// Row voltage in uV, falling with the index
	function automatic logic [VOLT_W-1:0] rom_volt(input logic [ROW_W-1:0] idx);
		case (idx)
			0:       rom_volt = 23'd2838012;
			1:       rom_volt = 23'd2295013;
			2:       rom_volt = 23'd1995715;
			3:       rom_volt = 23'd1665955;
			4:       rom_volt = 23'd1500000;
			5:       rom_volt = 23'd1338778;
			6:       rom_volt = 23'd1185666;
			7:       rom_volt = 23'd1043052;
			8:       rom_volt = 23'd912607;
			9:       rom_volt = 23'd794928;
			10:      rom_volt = 23'd690353;
			11:      rom_volt = 23'd598078;
			12:      rom_volt = 23'd517378;
			13:      rom_volt = 23'd334754;
			14:      rom_volt = 23'd190300;
			15:      rom_volt = 23'd53797;
			default: rom_volt = 23'd18980;
		endcase
	endfunction

endpackage

### rtl/tvt_lut_search.sv
// Table search: clamps at the table ends, else walks the rows one per cycle
// to find the bracketing pair and forms the interpolation operands.
// Depends on tvt_pkg.
module tvt_lut_search import tvt_pkg::*; #(
	parameter int ROWS = TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VOLT_W-1:0] sense_uv,
	output logic              done,
	output lut_op_t           op
);

	localparam logic [ROW_W-1:0] LAST = ROW_W'(ROWS - 1);
	localparam logic [ROW_W-1:0] PEN  = ROW_W'(ROWS - 2);

	logic              active_q;
	logic              done_q;
	logic [ROW_W-1:0]  idx_q;
	logic [VOLT_W-1:0] u_q;
	lut_op_t           op_q;

	logic                     cold, hot, hit;
	logic [VOLT_W-1:0]        v_hi, v_lo;
	logic signed [TEMP_W-1:0] t_hi, t_lo, dt_full;
	logic [VOLT_W-1:0]        dv;

	// end clamps, checked on the incoming beat
	assign cold = sense_uv >= rom_volt('0);
	assign hot  = sense_uv <= rom_volt(LAST);

	// current row pair
	assign v_hi    = rom_volt(idx_q);
	assign v_lo    = rom_volt(idx_q + 1'b1);
	assign t_hi    = rom_temp(idx_q);
	assign t_lo    = rom_temp(idx_q + 1'b1);
	assign dt_full = t_lo - t_hi;
	assign dv      = v_hi - v_lo;
	assign hit     = ((u_q <= v_hi) && (u_q >= v_lo)) || (idx_q == PEN);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				idx_q <= '0;
				if (cold || hot) begin
					done_q <= 1'b1;
				end else begin
					active_q <= 1'b1;
				end
			end else if (active_q) begin
				if (hit) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// operands
	always_ff @(posedge clk) begin
		if (start) begin
			u_q      <= sense_uv;
			op_q.dt  <= '0;
			op_q.dm  <= '0;
			op_q.dv  <= '0;
			op_q.clamp <= 1'b1;
			op_q.t1  <= cold ? rom_temp('0) : rom_temp(LAST);
		end else if (active_q && hit) begin
			op_q.clamp <= (dv == '0);
			op_q.t1    <= t_hi;
			op_q.dt    <= dt_full[DT_W-1:0];
			op_q.dm    <= v_hi - u_q;
			op_q.dv    <= dv;
		end
	end

	assign done = done_q;
	assign op   = op_q;

endmodule

### rtl/tvt_serial_mult.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MSB first.
// Depends on tvt_pkg.
module tvt_serial_mult import tvt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DT_W-1:0]   mplier,
	input  logic [VOLT_W-1:0] mcand,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PROD_W-1:0] prod_q;
	logic [DT_W-1:0]   mplier_q;
	logic [VOLT_W-1:0] mcand_q;
	logic [PROD_W-1:0] prod_next;

	// one partial product per step
	assign prod_next = {prod_q[PROD_W-2:0], 1'b0}
		+ (mplier_q[DT_W-1] ? PROD_W'(mcand_q) : '0);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DT_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q   <= '0;
			mplier_q <= mplier;
			mcand_q  <= mcand;
		end else if (cnt_q != '0) begin
			prod_q   <= prod_next;
			mplier_q <= {mplier_q[DT_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

### rtl/tvt_serial_div.sv
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit DT_W bits, so the upper dividend bits seed the partial remainder.
// Depends on tvt_pkg.
module tvt_serial_div import tvt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [VOLT_W-1:0] divisor,
	output logic              done,
	output logic [DT_W-1:0]   quotient
);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [VOLT_W-1:0] rem_q;
	logic [DT_W-1:0]   low_q;
	logic [VOLT_W-1:0] dv_q;
	logic [VOLT_W:0]   trial, diff;
	logic              ge;

	// trial subtract
	assign trial = {rem_q, low_q[DT_W-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign ge    = trial >= {1'b0, dv_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DT_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:DT_W];
			low_q <= dividend[DT_W-1:0];
			dv_q  <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[VOLT_W-1:0] : trial[VOLT_W-1:0];
			low_q <= {low_q[DT_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

### rtl/thermistor_voltage_to_temperature.sv
// Thermistor voltage (uV) to temperature (mC), piecewise-linear table.
// A beat that clamps at a table end needs only the search; otherwise the search
// walks rows 0..k to the bracketing row k (0..ROWS-2), then a serial multiply
// and a serial divide run, with handoff, before the result is registered.
// One beat in flight; busy is high from accept until the result strobe.
// arst_n clears the sequencer and strobes; the result port is not cleared.
module thermistor_voltage_to_temperature import tvt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [VOLT_W-1:0]       sense_uv,
	output logic                    done,
	output logic signed [OUT_W-1:0] temp_mc
);

	localparam int ROWS = (TABLE_ENTRIES < 2) ? 2
		: ((TABLE_ENTRIES > ROM_ROWS) ? ROM_ROWS : TABLE_ENTRIES);

	tvt_state_t state_q, state_d;

	logic              srch_start, srch_done;
	lut_op_t           srch_op;
	logic              mul_start, mul_done;
	logic [PROD_W-1:0] mul_prod;
	logic              div_start, div_done;
	logic [DT_W-1:0]   div_quot;

	logic                     load_clamp, load_interp;
	logic signed [TEMP_W-1:0] interp;
	logic                     done_q;
	logic signed [OUT_W-1:0]  temp_mc_q;

	tvt_lut_search #(.ROWS(ROWS)) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (srch_start),
		.sense_uv (sense_uv),
		.done     (srch_done),
		.op       (srch_op)
	);

	tvt_serial_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mplier (srch_op.dt),
		.mcand  (srch_op.dm),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tvt_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod),
		.divisor  (srch_op.dv),
		.done     (div_done),
		.quotient (div_quot)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit starts
	always_comb begin
		state_d     = state_q;
		srch_start  = 1'b0;
		mul_start   = 1'b0;
		div_start   = 1'b0;
		load_clamp  = 1'b0;
		load_interp = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					srch_start = 1'b1;
					state_d    = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (srch_done) begin
					if (srch_op.clamp) begin
						load_clamp = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						mul_start = 1'b1;
						state_d   = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					load_interp = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign interp = srch_op.t1 + $signed({{(TEMP_W-DT_W){1'b0}}, div_quot});

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= load_clamp || load_interp;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_clamp) begin
			temp_mc_q <= srch_op.t1[OUT_W-1:0];
		end else if (load_interp) begin
			temp_mc_q <= interp[OUT_W-1:0];
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign temp_mc = temp_mc_q;

	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// a result only follows work in progress
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a beat in flight");

	// the search and the serial units never finish together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({srch_done, mul_done, div_done}))
		else $error("two units finished in the same cycle");

	// results stay between the table end temperatures
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (temp_mc >= -19'sd30000) && (temp_mc <= 19'sd200000))
		else $error("temperature outside table range");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for thermistor_voltage_to_temperature: directed and random voltages checked
// against an independent table interpolation. Depends on rtl/tvt_pkg.sv and the top RTL.
module tb;
	import tvt_pkg::*;

	localparam int ROWS_USED   = 17;
	localparam int RAND_ITEMS  = 1800;
	localparam int TAIL_CYCLES = 64;
	localparam int CYCLE_LIMIT = 600000;

	// Predicts each conversion and holds the temperatures still owed by the block
	class conversion_ledger;
		int unsigned              row_volt [tvt_pkg::ROM_ROWS];
		int                       row_temp [tvt_pkg::ROM_ROWS];
		int                       rows;
		int                       errors;
		logic signed [tvt_pkg::OUT_W-1:0] owed_temps [$];

		function new(int n);
			row_volt = '{2838012, 2295013, 1995715, 1665955, 1500000, 1338778, 1185666,
				1043052, 912607, 794928, 690353, 598078, 517378, 334754, 190300, 53797, 18980};
			row_temp = '{-30000, 0, 10000, 20000, 25000, 30000, 35000, 40000, 45000,
				50000, 55000, 60000, 65000, 80000, 100000, 150000, 200000};
			rows = (n < 2) ? 2 : ((n > tvt_pkg::ROM_ROWS) ? tvt_pkg::ROM_ROWS : n);
			errors = 0;
		endfunction

		// Clamp at the table ends, else interpolate in the first bracketing pair
		function logic signed [tvt_pkg::OUT_W-1:0] predict_temperature(
				logic [tvt_pkg::VOLT_W-1:0] u);
			longint t;
			longint dt;
			longint dm;
			longint dv;
			int     sel;
			bit     found;
			sel = rows - 2;
			found = 1'b0;
			if (u >= row_volt[0]) begin
				t = row_temp[0];
			end else if (u <= row_volt[rows-1]) begin
				t = row_temp[rows-1];
			end else begin
				for (int i = 0; i + 1 < rows; i++) begin
					if (!found && u <= row_volt[i] && u >= row_volt[i+1]) begin
						sel = i;
						found = 1'b1;
					end
				end
				dt = longint'(row_temp[sel+1]) - longint'(row_temp[sel]);
				dm = longint'(row_volt[sel]) - longint'(u);
				dv = longint'(row_volt[sel]) - longint'(row_volt[sel+1]);
				if (dv == 0)
					t = row_temp[sel];
				else
					t = longint'(row_temp[sel]) + (dt * dm) / dv;
			end
			return t[tvt_pkg::OUT_W-1:0];
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $realtime, what);
		endtask

		function void note_voltage(logic [tvt_pkg::VOLT_W-1:0] u);
			owed_temps.push_back(predict_temperature(u));
		endfunction

		task check_temperature(logic signed [tvt_pkg::OUT_W-1:0] got);
			logic signed [tvt_pkg::OUT_W-1:0] want;
			if (owed_temps.size() == 0) begin
				report($sformatf("unexpected result %0d", got));
			end else begin
				want = owed_temps.pop_front();
				if (got !== want)
					report($sformatf("temp_mc %0d, expected %0d", got, want));
			end
		endtask

		function int pending();
			return owed_temps.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [VOLT_W-1:0]       sense_uv = '0;
	logic                    busy;
	logic                    done;
	logic signed [OUT_W-1:0] temp_mc;

	conversion_ledger ledger = new(ROWS_USED);
	int unsigned      cycles = 0;
	int               burst_left = 0;

	thermistor_voltage_to_temperature #(
		.TABLE_ENTRIES(ROWS_USED)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sense_uv (sense_uv),
		.done     (done),
		.temp_mc  (temp_mc)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL thermistor_voltage_to_temperature");
			$finish;
		end
	end

	// Result beats cannot be held off: take every strobe
	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_temperature(temp_mc);
	end

	// Gap before the next beat; occasional back-to-back bursts
	function int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(99, 0) < 3)
			burst_left = $urandom_range(50, 10);
		return $urandom_range(9, 0);
	endfunction

	// Mostly in-table voltages, with row edges, clamps and raw noise mixed in
	function logic [VOLT_W-1:0] draw_voltage();
		int unsigned r;
		int unsigned row;
		r = $urandom_range(99, 0);
		if (r < 55) begin
			return VOLT_W'($urandom_range(2838011, 18981));
		end else if (r < 70) begin
			row = $urandom_range(ROM_ROWS - 1, 0);
			return VOLT_W'(ledger.row_volt[row] + $urandom_range(4, 0) - 2);
		end else if (r < 85) begin
			return VOLT_W'($urandom);
		end else if (r < 90) begin
			return VOLT_W'($urandom_range(2838012 + 3000, 2838012 - 3000));
		end else if (r < 96) begin
			return VOLT_W'($urandom_range(22000, 0));
		end else begin
			case ($urandom_range(2, 0))
				0:       return '0;
				1:       return '1;
				default: return VOLT_W'(6553500);
			endcase
		end
	endfunction

	// One input beat: optional idle gap, then hold start until accepted
	task send_voltage(logic [VOLT_W-1:0] v, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sense_uv <= v;
		do @(posedge clk); while (busy);
		ledger.note_voltage(v);
	endtask

	// Let every owed result come back before going on
	task drain();
		start <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	logic [VOLT_W-1:0] corner_volts [23] = '{
		23'd0, 23'd8388607, 23'd6553500,
		23'd2838012, 23'd2838013, 23'd2838011,
		23'd18980, 23'd18981, 23'd18979,
		23'd2295013, 23'd2295012, 23'd1500000, 23'd1499999,
		23'd912607, 23'd334754, 23'd190301, 23'd53797, 23'd53796,
		23'd100000, 23'd4194304, 23'd2000000, 23'd600000, 23'd25000
	};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: range ends, clamp boundaries, exact row voltages and neighbors
		foreach (corner_volts[k])
			send_voltage(corner_volts[k], draw_gap());
		drain();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			send_voltage(draw_voltage(), draw_gap());
			if (n % 600 == 300)
				drain();
		end
		start <= 1'b0;

		while (ledger.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (ledger.errors == 0)
			$display("PASS thermistor_voltage_to_temperature");
		else
			$display("FAIL thermistor_voltage_to_temperature");
		$finish;
	end

endmodule

### sim.f
rtl/tvt_pkg.sv
rtl/tvt_lut_search.sv
rtl/tvt_serial_mult.sv
rtl/tvt_serial_div.sv
rtl/thermistor_voltage_to_temperature.sv
tb/sv/tb.sv
